>>> hdl/obb_pkg.sv
// Shared widths, stage count and the mid-pipeline bundle for the OBB overlap test.
// No dependencies; imported by every RTL module except obb_checker.
package obb_pkg;

  localparam int NUM_STAGES = 5;

  localparam int POS_W      = 32;  // Q16.16 center coordinate
  localparam int DIFF_W     = 33;  // center difference
  localparam int HALF_W     = 31;  // UQ15.16 half extent
  localparam int TRIG_W     = 16;  // Q2.14 cos / sin
  localparam int TPROD_W    = 32;  // trig product
  localparam int CS_W       = 32;  // |cos diff| / |sin diff| magnitude
  localparam int DPROD_W    = 49;  // difference times trig
  localparam int DMAG_W     = 49;  // projected distance magnitude
  localparam int RPROD_W    = 63;  // half extent times cs magnitude
  localparam int ACC_W      = 64;  // Q.44 comparison width
  localparam int OWN_SHIFT  = 28;
  localparam int DIST_SHIFT = 14;

  // Handoff from the front datapath to the back datapath
  typedef struct packed {
    logic signed [DPROD_W-1:0] dx_ca;
    logic signed [DPROD_W-1:0] dy_sa;
    logic signed [DPROD_W-1:0] dy_ca;
    logic signed [DPROD_W-1:0] dx_sa;
    logic signed [DPROD_W-1:0] dx_cb;
    logic signed [DPROD_W-1:0] dy_sb;
    logic signed [DPROD_W-1:0] dy_cb;
    logic signed [DPROD_W-1:0] dx_sb;
    logic [CS_W-1:0]           c;
    logic [CS_W-1:0]           s;
    logic [HALF_W-1:0]         ahw;
    logic [HALF_W-1:0]         ahh;
    logic [HALF_W-1:0]         bhw;
    logic [HALF_W-1:0]         bhh;
  } obb_mid_t;

endpackage

>>> hdl/obb_overlap_test_2d.sv
// Top level of the 2D oriented-box overlap test.
// Depends on obb_pkg, obb_pipe_ctl, obb_front and obb_back.
//
// Usage:
//   Input channel pair_valid / pair_ready carries one box pair per transfer:
//   centers (Q16.16), half extents (UQ15.16) and cos/sin (Q2.14) of A and B.
//   Output channel result_valid / result_ready carries one overlap bit per
//   pair, in input order: 1 when none of the four box axes separates them.
//   An accepted pair moves through stages 0 to 4 in order; result_valid rises
//   when it reaches the stage 4 output register.
//   Throughput: one pair per cycle while result_ready stays high; the rate is
//   set by the five-stage register pipeline (difference/trig products,
//   projection multiplies, magnitudes and radius multiplies, radius sums, compare).
//   Every stage has a valid bit and loads when empty or when the stage
//   after it moves on, so a stalled receiver backs the pipeline up one
//   stage at a time; pair_ready falls only once all stages hold items.
//   Nothing is dropped or repeated under stall.
//   Reset (rst, synchronous) clears all valid bits; the datapath holds no
//   state beyond the items in flight.
module obb_overlap_test_2d (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pair_valid,
  output logic                              pair_ready,
  input  logic signed [obb_pkg::POS_W-1:0]  a_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]  a_center_y,
  input  logic [obb_pkg::HALF_W-1:0]        a_half_width,
  input  logic [obb_pkg::HALF_W-1:0]        a_half_height,
  input  logic signed [obb_pkg::TRIG_W-1:0] a_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0] a_sin,
  input  logic signed [obb_pkg::POS_W-1:0]  b_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]  b_center_y,
  input  logic [obb_pkg::HALF_W-1:0]        b_half_width,
  input  logic [obb_pkg::HALF_W-1:0]        b_half_height,
  input  logic signed [obb_pkg::TRIG_W-1:0] b_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0] b_sin,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              overlap
);
  import obb_pkg::*;

  logic [NUM_STAGES-1:0] en;   // per-stage load enables
  obb_mid_t              mid;  // projection products, cs magnitudes, extents

  // handshake and valid bits
  obb_pipe_ctl u_ctl (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .en           (en)
  );

  // stages 0-1
  obb_front u_front (
    .clk           (clk),
    .en            (en),
    .a_center_x    (a_center_x),
    .a_center_y    (a_center_y),
    .a_half_width  (a_half_width),
    .a_half_height (a_half_height),
    .a_cos         (a_cos),
    .a_sin         (a_sin),
    .b_center_x    (b_center_x),
    .b_center_y    (b_center_y),
    .b_half_width  (b_half_width),
    .b_half_height (b_half_height),
    .b_cos         (b_cos),
    .b_sin         (b_sin),
    .mid           (mid)
  );

  // stages 2-4, last stage is the output register
  obb_back u_back (
    .clk     (clk),
    .en      (en),
    .mid     (mid),
    .overlap (overlap)
  );

endmodule

>>> hdl/obb_pipe_ctl.sv
// Valid bits and stage enables for the OBB pipeline.
// Depends on obb_pkg.
module obb_pipe_ctl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pair_valid,
  output logic                          pair_ready,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [obb_pkg::NUM_STAGES-1:0] en
);
  import obb_pkg::*;

  logic [NUM_STAGES-1:0] vld;

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || result_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pair_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign pair_ready   = en[0];
  assign result_valid = vld[NUM_STAGES-1];

endmodule

>>> hdl/obb_front.sv
// Stages 0-1: center difference, relative rotation and projection products.
// Depends on obb_pkg.
module obb_front (
  input  logic                            clk,
  input  logic [obb_pkg::NUM_STAGES-1:0]  en,
  input  logic signed [obb_pkg::POS_W-1:0]  a_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]  a_center_y,
  input  logic [obb_pkg::HALF_W-1:0]        a_half_width,
  input  logic [obb_pkg::HALF_W-1:0]        a_half_height,
  input  logic signed [obb_pkg::TRIG_W-1:0] a_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0] a_sin,
  input  logic signed [obb_pkg::POS_W-1:0]  b_center_x,
  input  logic signed [obb_pkg::POS_W-1:0]  b_center_y,
  input  logic [obb_pkg::HALF_W-1:0]        b_half_width,
  input  logic [obb_pkg::HALF_W-1:0]        b_half_height,
  input  logic signed [obb_pkg::TRIG_W-1:0] b_cos,
  input  logic signed [obb_pkg::TRIG_W-1:0] b_sin,
  output obb_pkg::obb_mid_t                 mid
);
  import obb_pkg::*;

  // stage 0 registers
  logic signed [DIFF_W-1:0]  dx, dy;
  logic signed [TPROD_W-1:0] p_cc, p_ss, p_scb, p_csb;
  logic signed [TRIG_W-1:0]  ca, sa, cb, sb;
  logic [HALF_W-1:0]         ahw, ahh, bhw, bhh;

  // stage 1 combinational
  logic signed [TPROD_W:0] c_sum, s_sum, c_neg, s_neg;
  logic [CS_W-1:0]         c_mag, s_mag;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx    <= {a_center_x[POS_W-1], a_center_x} - {b_center_x[POS_W-1], b_center_x};
      dy    <= {a_center_y[POS_W-1], a_center_y} - {b_center_y[POS_W-1], b_center_y};
      p_cc  <= a_cos * b_cos;
      p_ss  <= a_sin * b_sin;
      p_scb <= a_sin * b_cos;
      p_csb <= a_cos * b_sin;
      ca    <= a_cos;
      sa    <= a_sin;
      cb    <= b_cos;
      sb    <= b_sin;
      ahw   <= a_half_width;
      ahh   <= a_half_height;
      bhw   <= b_half_width;
      bhh   <= b_half_height;
    end
  end

  // |ca*cb + sa*sb| and |sa*cb - ca*sb|
  always_comb begin
    c_sum = {p_cc[TPROD_W-1], p_cc} + {p_ss[TPROD_W-1], p_ss};
    s_sum = {p_scb[TPROD_W-1], p_scb} - {p_csb[TPROD_W-1], p_csb};
    c_neg = -c_sum;
    s_neg = -s_sum;
    c_mag = c_sum[TPROD_W] ? c_neg[CS_W-1:0] : c_sum[CS_W-1:0];
    s_mag = s_sum[TPROD_W] ? s_neg[CS_W-1:0] : s_sum[CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mid.dx_ca <= dx * ca;
      mid.dy_sa <= dy * sa;
      mid.dy_ca <= dy * ca;
      mid.dx_sa <= dx * sa;
      mid.dx_cb <= dx * cb;
      mid.dy_sb <= dy * sb;
      mid.dy_cb <= dy * cb;
      mid.dx_sb <= dx * sb;
      mid.c     <= c_mag;
      mid.s     <= s_mag;
      mid.ahw   <= ahw;
      mid.ahh   <= ahh;
      mid.bhw   <= bhw;
      mid.bhh   <= bhh;
    end
  end

endmodule

>>> hdl/obb_back.sv
// Stages 2-4: distance magnitudes, radius sums and the separating-axis compare.
// Depends on obb_pkg.
module obb_back (
  input  logic                           clk,
  input  logic [obb_pkg::NUM_STAGES-1:0] en,
  input  obb_pkg::obb_mid_t              mid,
  output logic                           overlap
);
  import obb_pkg::*;

  localparam int NUM_AXES = 4;
  localparam int PAD_W    = ACC_W - HALF_W - OWN_SHIFT;

  logic signed [DPROD_W:0] proj [NUM_AXES];
  logic signed [DPROD_W:0] proj_neg [NUM_AXES];
  logic [DMAG_W-1:0]       dmag [NUM_AXES];

  // stage 2 registers
  logic [DMAG_W-1:0]  dist2 [NUM_AXES];
  logic [RPROD_W-1:0] rp_w  [NUM_AXES];
  logic [RPROD_W-1:0] rp_h  [NUM_AXES];
  logic [HALF_W-1:0]  own2  [NUM_AXES];

  // stage 3 registers
  logic [ACC_W-1:0] dist3 [NUM_AXES];
  logic [ACC_W-1:0] rad3  [NUM_AXES];

  logic [NUM_AXES-1:0] sep;

  // axis order: A.u, A.v, B.u, B.v
  always_comb begin
    proj[0] = {mid.dx_ca[DPROD_W-1], mid.dx_ca} + {mid.dy_sa[DPROD_W-1], mid.dy_sa};
    proj[1] = {mid.dy_ca[DPROD_W-1], mid.dy_ca} - {mid.dx_sa[DPROD_W-1], mid.dx_sa};
    proj[2] = {mid.dx_cb[DPROD_W-1], mid.dx_cb} + {mid.dy_sb[DPROD_W-1], mid.dy_sb};
    proj[3] = {mid.dy_cb[DPROD_W-1], mid.dy_cb} - {mid.dx_sb[DPROD_W-1], mid.dx_sb};
    for (int i = 0; i < NUM_AXES; i++) begin
      proj_neg[i] = -proj[i];
      dmag[i] = proj[i][DPROD_W] ? proj_neg[i][DMAG_W-1:0] : proj[i][DMAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dist2[i] <= dmag[i];
      end
      // radius of the other box on each axis
      rp_w[0] <= mid.bhw * mid.c;
      rp_h[0] <= mid.bhh * mid.s;
      rp_w[1] <= mid.bhw * mid.s;
      rp_h[1] <= mid.bhh * mid.c;
      rp_w[2] <= mid.ahw * mid.c;
      rp_h[2] <= mid.ahh * mid.s;
      rp_w[3] <= mid.ahw * mid.s;
      rp_h[3] <= mid.ahh * mid.c;
      own2[0] <= mid.ahw;
      own2[1] <= mid.ahh;
      own2[2] <= mid.bhw;
      own2[3] <= mid.bhh;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        dist3[i] <= {1'b0, dist2[i], {DIST_SHIFT{1'b0}}};
        rad3[i]  <= {{PAD_W{1'b0}}, own2[i], {OWN_SHIFT{1'b0}}}
                    + {1'b0, rp_w[i]} + {1'b0, rp_h[i]};
      end
    end
  end

  // touching counts as overlap
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      sep[i] = dist3[i] > rad3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      overlap <= !(|sep);
    end
  end

endmodule

>>> hdl/obb_checker.sv
// Port-level assertions for obb_overlap_test_2d and the bind that attaches them.
// Depends on obb_overlap_test_2d port names.
module obb_checker (
  input logic clk,
  input logic rst,
  input logic pair_valid,
  input logic pair_ready,
  input logic result_valid,
  input logic result_ready,
  input logic overlap
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(overlap))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // pipeline can only be full when the output is stuck
  a_ready_free: assert property (@(posedge clk)
    (!result_valid || result_ready) |-> pair_ready)
    else $error("input stalled with output free");

endmodule

bind obb_overlap_test_2d obb_checker u_chk (.*);

>>> tb/sv/testbench.sv
// Testbench for obb_overlap_test_2d: directed and random box pairs against a built-in predictor.
// Depends on obb_pkg and the obb_overlap_test_2d RTL. Stands alone otherwise.
`timescale 1ns / 100ps

module testbench;
  import obb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000; // far above the slowest legal run
  localparam int DRAIN_CYCLES = 20;     // pipeline is 5 deep; leave room for late stalls

  localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0]  POS_MIN  = 32'sh8000_0000;
  localparam logic signed [POS_W-1:0]  ONE      = 32'sh0001_0000; // 1.0 in Q16.16
  localparam logic [HALF_W-1:0]        HALF_MAX = 31'h7FFF_FFFF;
  localparam logic [HALF_W-1:0]        HALF_ONE = 31'h0001_0000;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;     // 1.0 in Q2.14
  localparam logic signed [TRIG_W-1:0] TRIG_HI  = 16'sh7FFF;      // beyond +1.0
  localparam logic signed [TRIG_W-1:0] TRIG_LO  = 16'sh8000;      // beyond -1.0
  localparam logic signed [TRIG_W-1:0] TRIG_R2  = 16'sd11585;     // ~cos(45 deg)
  localparam real                      PI       = 3.14159265358979;

  // One box pair, as carried by one input transfer
  typedef struct packed {
    logic signed [POS_W-1:0]  a_center_x;
    logic signed [POS_W-1:0]  a_center_y;
    logic [HALF_W-1:0]        a_half_width;
    logic [HALF_W-1:0]        a_half_height;
    logic signed [TRIG_W-1:0] a_cos;
    logic signed [TRIG_W-1:0] a_sin;
    logic signed [POS_W-1:0]  b_center_x;
    logic signed [POS_W-1:0]  b_center_y;
    logic [HALF_W-1:0]        b_half_width;
    logic [HALF_W-1:0]        b_half_height;
    logic signed [TRIG_W-1:0] b_cos;
    logic signed [TRIG_W-1:0] b_sin;
  } box_pair_t;

  // Every input starts at a known value
  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     pair_valid    = 1'b0;
  logic                     pair_ready;
  logic signed [POS_W-1:0]  a_center_x    = '0;
  logic signed [POS_W-1:0]  a_center_y    = '0;
  logic [HALF_W-1:0]        a_half_width  = '0;
  logic [HALF_W-1:0]        a_half_height = '0;
  logic signed [TRIG_W-1:0] a_cos         = '0;
  logic signed [TRIG_W-1:0] a_sin         = '0;
  logic signed [POS_W-1:0]  b_center_x    = '0;
  logic signed [POS_W-1:0]  b_center_y    = '0;
  logic [HALF_W-1:0]        b_half_width  = '0;
  logic [HALF_W-1:0]        b_half_height = '0;
  logic signed [TRIG_W-1:0] b_cos         = '0;
  logic signed [TRIG_W-1:0] b_sin         = '0;
  logic                     result_valid;
  logic                     result_ready  = 1'b0;
  logic                     overlap;

  logic expected_overlap[$];   // predicted overlap bits, oldest first
  logic want_overlap;
  int   error_count = 0;
  int   cycle_count = 0;
  int   idle_pct    = 0;       // chance (percent) the sender idles a cycle
  int   stall_pct   = 0;       // chance (percent) the receiver stalls a cycle

  obb_overlap_test_2d uut (
    .clk          (clk),
    .rst          (rst),
    .pair_valid   (pair_valid),
    .pair_ready   (pair_ready),
    .a_center_x   (a_center_x),
    .a_center_y   (a_center_y),
    .a_half_width (a_half_width),
    .a_half_height(a_half_height),
    .a_cos        (a_cos),
    .a_sin        (a_sin),
    .b_center_x   (b_center_x),
    .b_center_y   (b_center_y),
    .b_half_width (b_half_width),
    .b_half_height(b_half_height),
    .b_cos        (b_cos),
    .b_sin        (b_sin),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .overlap      (overlap)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Everything is exact: center difference is 33 bits, projections
  // stay under 2^49 before the Q.44 scale, and radii are summed at 66 bits so
  // no term can wrap even with out-of-range trig values.
  // ---------------------------------------------------------------------------

  // |dx*x + dy*y| scaled from Q19.30 to Q.44
  function automatic logic [65:0] projected_gap(longint dx, longint dy, longint x, longint y);
    longint v;
    v = dx * x + dy * y;
    if (v < 0) v = -v;
    return {2'b00, v} << DIST_SHIFT;
  endfunction

  // Axis separates when the gap strictly exceeds the sum of both radii; touching is overlap
  function automatic logic axis_separates(logic [65:0] gap, logic [HALF_W-1:0] own_half,
                                          logic [HALF_W-1:0] ext_w, logic [HALF_W-1:0] ext_h,
                                          logic [65:0] k_w, logic [65:0] k_h);
    logic [65:0] reach;
    reach = ({35'b0, own_half} << OWN_SHIFT) + ext_w * k_w + ext_h * k_h;
    return gap > reach;
  endfunction

  function automatic logic pair_overlaps(box_pair_t p);
    longint      dx, dy, ca, sa, cb, sb, c_rel, s_rel;
    logic [65:0] c_wide, s_wide;
    logic        split;
    dx = longint'(p.a_center_x) - longint'(p.b_center_x);
    dy = longint'(p.a_center_y) - longint'(p.b_center_y);
    ca = longint'(p.a_cos);
    sa = longint'(p.a_sin);
    cb = longint'(p.b_cos);
    sb = longint'(p.b_sin);
    // cos and sin of the relative rotation, as magnitudes
    c_rel = ca * cb + sa * sb;
    s_rel = sa * cb - ca * sb;
    if (c_rel < 0) c_rel = -c_rel;
    if (s_rel < 0) s_rel = -s_rel;
    c_wide = {2'b00, c_rel};
    s_wide = {2'b00, s_rel};
    split = axis_separates(projected_gap(dx, dy, ca, sa), p.a_half_width,
                           p.b_half_width, p.b_half_height, c_wide, s_wide)
         || axis_separates(projected_gap(dx, dy, -sa, ca), p.a_half_height,
                           p.b_half_width, p.b_half_height, s_wide, c_wide)
         || axis_separates(projected_gap(dx, dy, cb, sb), p.b_half_width,
                           p.a_half_width, p.a_half_height, c_wide, s_wide)
         || axis_separates(projected_gap(dx, dy, -sb, cb), p.b_half_height,
                           p.a_half_width, p.a_half_height, s_wide, c_wide);
    return !split;
  endfunction

  function automatic box_pair_t make_pair(
      logic signed [POS_W-1:0] acx, logic signed [POS_W-1:0] acy,
      logic [HALF_W-1:0] ahw, logic [HALF_W-1:0] ahh,
      logic signed [TRIG_W-1:0] ac, logic signed [TRIG_W-1:0] as_,
      logic signed [POS_W-1:0] bcx, logic signed [POS_W-1:0] bcy,
      logic [HALF_W-1:0] bhw, logic [HALF_W-1:0] bhh,
      logic signed [TRIG_W-1:0] bc, logic signed [TRIG_W-1:0] bs);
    box_pair_t p;
    p.a_center_x = acx;  p.a_center_y = acy;
    p.a_half_width = ahw; p.a_half_height = ahh;
    p.a_cos = ac;  p.a_sin = as_;
    p.b_center_x = bcx;  p.b_center_y = bcy;
    p.b_half_width = bhw; p.b_half_height = bhh;
    p.b_cos = bc;  p.b_sin = bs;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call. Valid only drops in idle cycles, so a
  // back-to-back pair keeps valid high through the step of the prior transfer.
  // ---------------------------------------------------------------------------
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair_valid    <= 1'b1;
    a_center_x    <= p.a_center_x;
    a_center_y    <= p.a_center_y;
    a_half_width  <= p.a_half_width;
    a_half_height <= p.a_half_height;
    a_cos         <= p.a_cos;
    a_sin         <= p.a_sin;
    b_center_x    <= p.b_center_x;
    b_center_y    <= p.b_center_y;
    b_half_width  <= p.b_half_width;
    b_half_height <= p.b_half_height;
    b_cos         <= p.b_cos;
    b_sin         <= p.b_sin;
    @(posedge clk);
    while (!pair_ready) @(posedge clk);
    expected_overlap.push_back(pair_overlaps(p));
  endtask

  // Output side: random backpressure at the current stall rate
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: every transfer must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_overlap.size() == 0) begin
        $error("overlap: expected none, actual %b", overlap);
        error_count++;
      end else begin
        want_overlap = expected_overlap.pop_front();
        if (overlap !== want_overlap) begin
          $error("overlap: expected %b, actual %b", want_overlap, overlap);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes: zero, full-scale centers, widest extents, trig limits
  task automatic test_field_extremes();
    send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_pair(make_pair(POS_MAX, POS_MAX, '0, '0, TRIG_ONE, '0,
                        POS_MIN, POS_MIN, '0, '0, TRIG_ONE, '0));
    send_pair(make_pair(POS_MIN, POS_MAX, HALF_MAX, HALF_MAX, -TRIG_ONE, TRIG_ONE,
                        POS_MAX, POS_MIN, HALF_MAX, HALF_MAX, TRIG_ONE, -TRIG_ONE));
    send_pair(make_pair(POS_MAX, POS_MIN, HALF_MAX, HALF_MAX, TRIG_R2, TRIG_R2,
                        POS_MIN, POS_MAX, HALF_MAX, HALF_MAX, -TRIG_R2, TRIG_R2));
    send_pair(make_pair(POS_MIN, POS_MIN, HALF_MAX, '0, TRIG_ONE, '0,
                        POS_MIN, POS_MIN, '0, HALF_MAX, '0, TRIG_ONE));
    send_pair(make_pair(-ONE, ONE, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        ONE, -ONE, HALF_ONE, HALF_ONE, TRIG_R2, -TRIG_R2));
  endtask

  // Touching boxes count as overlap; one LSB further apart they separate
  task automatic test_touching_axes();
    // along A.u (x), then A.v (y)
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        2 * ONE, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        2 * ONE + 1, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        '0, -2 * ONE, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        '0, -2 * ONE - 1, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    // B turned a quarter: its height lies along x
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        2 * ONE, '0, HALF_W'(3 * HALF_ONE), HALF_ONE, '0, TRIG_ONE));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0,
                        2 * ONE + 1, '0, HALF_W'(3 * HALF_ONE), HALF_ONE, '0, TRIG_ONE));
    // A at 45 degrees beside an upright B: the decision falls on B's axes
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_R2, TRIG_R2,
                        2 * ONE + ONE / 2, '0, HALF_ONE, HALF_W'(4 * HALF_ONE),
                        TRIG_ONE, '0));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_R2, TRIG_R2,
                        2 * ONE + ONE / 3, ONE / 3, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
  endtask

  // Trig values used as given: beyond +-1.0, non-unit axes, all-zero axes
  task automatic test_unnormalized_trig();
    send_pair(make_pair(POS_MAX, POS_MIN, HALF_MAX, HALF_MAX, TRIG_LO, TRIG_LO,
                        POS_MIN, POS_MAX, HALF_MAX, HALF_MAX, TRIG_LO, TRIG_HI));
    send_pair(make_pair(POS_MIN, POS_MIN, HALF_MAX, HALF_MAX, TRIG_HI, TRIG_LO,
                        POS_MAX, POS_MAX, HALF_MAX, HALF_MAX, TRIG_HI, TRIG_HI));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_ONE, TRIG_ONE,
                        3 * ONE, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    send_pair(make_pair('0, '0, HALF_ONE, HALF_ONE, TRIG_W'(TRIG_ONE / 2), '0,
                        3 * ONE / 2, '0, HALF_ONE, HALF_ONE, TRIG_ONE, '0));
    send_pair(make_pair(POS_MAX, '0, HALF_ONE, HALF_ONE, '0, '0,
                        POS_MIN, '0, HALF_ONE, HALF_ONE, '0, '0));
  endtask

  // Random pairs. Most are nearby rotated boxes so both outcomes are common;
  // the rest are raw bit patterns that toggle every input bit.
  task automatic test_random_pairs(input int count, input int idle, input int stall);
    box_pair_t p;
    real       ang_a, ang_b;
    int        base_x, base_y, span;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30) begin
        p = make_pair($urandom(), $urandom(), HALF_W'($urandom()), HALF_W'($urandom()),
                      TRIG_W'($urandom()), TRIG_W'($urandom()),
                      $urandom(), $urandom(), HALF_W'($urandom()), HALF_W'($urandom()),
                      TRIG_W'($urandom()), TRIG_W'($urandom()));
        if ($urandom_range(1)) begin
          // keep the trig legal on half of them
          p.a_cos = TRIG_W'(int'($urandom_range(32768)) - 16384);
          p.a_sin = TRIG_W'(int'($urandom_range(32768)) - 16384);
          p.b_cos = TRIG_W'(int'($urandom_range(32768)) - 16384);
          p.b_sin = TRIG_W'(int'($urandom_range(32768)) - 16384);
        end
      end else begin
        // quarter turns now and then, otherwise any angle
        if ($urandom_range(99) < 15) begin
          ang_a = $urandom_range(3) * PI / 2.0;
          ang_b = $urandom_range(3) * PI / 2.0;
        end else begin
          ang_a = $urandom_range(99999) * 2.0 * PI / 100000.0;
          ang_b = $urandom_range(99999) * 2.0 * PI / 100000.0;
        end
        span   = 1 << 22;
        base_x = int'($urandom_range(32'h7FFF_FFFF)) - (1 << 30);
        base_y = int'($urandom_range(32'h7FFF_FFFF)) - (1 << 30);
        p.a_center_x    = base_x;
        p.a_center_y    = base_y;
        p.b_center_x    = base_x + int'($urandom_range(2 * span)) - span;
        p.b_center_y    = base_y + int'($urandom_range(2 * span)) - span;
        p.a_half_width  = ($urandom_range(19) == 0) ? '0 : HALF_W'($urandom_range(1 << 21));
        p.a_half_height = HALF_W'($urandom_range(1 << 21));
        p.b_half_width  = HALF_W'($urandom_range(1 << 21));
        p.b_half_height = ($urandom_range(19) == 0) ? '0 : HALF_W'($urandom_range(1 << 21));
        p.a_cos = TRIG_W'($rtoi(16384.0 * $cos(ang_a)));
        p.a_sin = TRIG_W'($rtoi(16384.0 * $sin(ang_a)));
        p.b_cos = TRIG_W'($rtoi(16384.0 * $cos(ang_b)));
        p.b_sin = TRIG_W'($rtoi(16384.0 * $sin(ang_b)));
      end
      send_pair(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed cases back to back, then four random
  // phases with different idle/stall mixes, then drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_touching_axes();
    test_unnormalized_trig();

    test_random_pairs(258, 0, 0);
    test_random_pairs(258, 67, 0);
    test_random_pairs(258, 0, 67);
    test_random_pairs(258, 34, 34);

    pair_valid <= 1'b0;
    while (expected_overlap.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/obb_pkg.sv
hdl/obb_pipe_ctl.sv
hdl/obb_front.sv
hdl/obb_back.sv
hdl/obb_overlap_test_2d.sv
hdl/obb_checker.sv
tb/sv/testbench.sv
